FILE: rtl/core/nru_pkg.sv
// Shared constants for the not-recently-used page replacement block.
// Holds field widths, reset values and parameter defaults; no dependencies.
package nru_pkg;

  localparam int unsigned DEF_MAX_FRAMES = 16;
  localparam int unsigned DEF_PAGE_BITS  = 8;

  // Frame limit register and resident count port widths.
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned COUNT_W = 5;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  // Page classes run 0..3; the ceiling sits above every real class.
  localparam int unsigned CLASS_W = 3;
  localparam logic [CLASS_W-1:0] CLASS_CEILING = CLASS_W'(4);

endpackage

FILE: rtl/core/nru_page_replacement.sv
// A request runs from acceptance through a scan of the resident pages to done_o on a hit or
// an append; an eviction adds a compaction pass over the entries after the victim.
// Throughput: one request at a time, paced by a single frame list port that the scan and the
// compaction share; a new request may be issued in the cycle done_o is high.
// After reset busy_o stays high while the page bit tables are cleared. The receiver cannot
// stall; done_o is a single-cycle strobe.
module nru_page_replacement #(
  parameter int unsigned MAX_FRAMES = nru_pkg::DEF_MAX_FRAMES,
  parameter int unsigned PAGE_BITS  = nru_pkg::DEF_PAGE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [PAGE_BITS-1:0]       page_i,
  input  logic                       kind_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic                       evicted_o,
  output logic [PAGE_BITS-1:0]       victim_page_o,
  output logic [nru_pkg::COUNT_W-1:0] resident_count_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [nru_pkg::CFG_W-1:0]  cfg_data_i
);
  import nru_pkg::*;

  localparam int unsigned IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned LEN_W      = $clog2(MAX_FRAMES + 1);
  localparam int unsigned LIM_W      = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int unsigned PAGE_SPACE = 1 << PAGE_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT
  } state_e;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     frames_q;
  logic [PAGE_BITS-1:0] clr_q, clr_d;
  logic [PAGE_BITS-1:0] pg_q, pg_d;
  logic                 kind_q, kind_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [LEN_W-1:0]     rd_idx_q, rd_idx_d;
  logic [LEN_W-1:0]     wr_idx_q, wr_idx_d;
  logic                 s1_valid_q, s1_valid_d;
  logic [LEN_W-1:0]     s1_idx_q, s1_idx_d;
  logic                 s2_valid_q, s2_valid_d;
  logic [LEN_W-1:0]     s2_idx_q, s2_idx_d;
  logic [PAGE_BITS-1:0] s2_page_q, s2_page_d;
  logic                 hit_q, hit_d;
  logic [CLASS_W-1:0]   least_q, least_d;
  logic [LEN_W-1:0]     pos_q, pos_d;
  logic [PAGE_BITS-1:0] victim_q, victim_d;
  logic                 done_q, done_d;
  logic                 out_hit_q, out_hit_d;
  logic                 out_ev_q, out_ev_d;
  logic [PAGE_BITS-1:0] out_vp_q, out_vp_d;
  logic [COUNT_W-1:0]   out_cnt_q, out_cnt_d;

  // Frame list memory: one write port, one registered read port.
  logic [PAGE_BITS-1:0] frame_mem [MAX_FRAMES];
  logic                 frame_we;
  logic [IDX_W-1:0]     frame_wa;
  logic [PAGE_BITS-1:0] frame_wd;
  logic [IDX_W-1:0]     frame_ra;
  logic [PAGE_BITS-1:0] frame_rd_q;

  // Referenced and modified bit tables, cleared by a sweep after reset.
  logic                 ref_mem [PAGE_SPACE];
  logic                 mod_mem [PAGE_SPACE];
  logic                 ref_we, mod_we, ref_wd, mod_wd;
  logic [PAGE_BITS-1:0] bit_wa;
  logic                 ref_rd_q, mod_rd_q;

  logic [LIM_W-1:0]     cfg_ext, lim;
  logic                 below_lim;
  logic                 issue;
  logic [LEN_W-1:0]     len_m1;
  logic [CLASS_W-1:0]   cls;

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign hit_o            = out_hit_q;
  assign evicted_o        = out_ev_q;
  assign victim_page_o    = out_vp_q;
  assign resident_count_o = out_cnt_q;
  assign cfg_ready_o      = 1'b1;

  // A limit of zero acts as one, and one above the list depth acts as the depth.
  assign cfg_ext   = LIM_W'(frames_q);
  assign lim       = (cfg_ext == '0) ? LIM_W'(1) :
                     (cfg_ext > LIM_W'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES) : cfg_ext;
  assign below_lim = (LIM_W'(len_q) < lim);
  assign issue     = (rd_idx_q < len_q);
  assign len_m1    = len_q - LEN_W'(1);
  assign cls       = {1'b0, ref_rd_q, mod_rd_q};

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pg_d       = pg_q;
    kind_d     = kind_q;
    len_d      = len_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    s1_valid_d = 1'b0;
    s1_idx_d   = rd_idx_q;
    s2_valid_d = 1'b0;
    s2_idx_d   = s1_idx_q;
    s2_page_d  = frame_rd_q;
    hit_d      = hit_q;
    least_d    = least_q;
    pos_d      = pos_q;
    victim_d   = victim_q;
    done_d     = 1'b0;
    out_hit_d  = out_hit_q;
    out_ev_d   = out_ev_q;
    out_vp_d   = out_vp_q;
    out_cnt_d  = out_cnt_q;
    frame_we   = 1'b0;
    frame_wa   = wr_idx_q[IDX_W-1:0];
    frame_wd   = frame_rd_q;
    frame_ra   = rd_idx_q[IDX_W-1:0];
    ref_we     = 1'b0;
    mod_we     = 1'b0;
    ref_wd     = 1'b1;
    mod_wd     = 1'b1;
    bit_wa     = pg_q;

    unique case (state_q)
      ST_CLEAR: begin
        ref_we = 1'b1;
        mod_we = 1'b1;
        ref_wd = 1'b0;
        mod_wd = 1'b0;
        bit_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          pg_d     = page_i;
          kind_d   = kind_i;
          rd_idx_d = '0;
          hit_d    = 1'b0;
          least_d  = CLASS_CEILING;
          pos_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Three-deep pipeline: list read, page compare and bit lookup, class compare.
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        s1_valid_d = issue;
        s2_valid_d = s1_valid_q;
        if (s1_valid_q && (frame_rd_q == pg_q)) begin
          hit_d = 1'b1;
        end
        if (s2_valid_q && (cls < least_q)) begin
          least_d  = cls;
          pos_d    = s2_idx_q;
          victim_d = s2_page_q;
        end
        if (!issue && !s1_valid_q && !s2_valid_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit_q || below_lim) begin
          if (!hit_q) begin
            frame_we = 1'b1;
            frame_wa = len_q[IDX_W-1:0];
            frame_wd = pg_q;
            len_d    = len_q + 1'b1;
          end
          ref_we    = 1'b1;
          mod_we    = kind_q;
          done_d    = 1'b1;
          out_hit_d = hit_q;
          out_ev_d  = 1'b0;
          out_vp_d  = '0;
          out_cnt_d = hit_q ? COUNT_W'(len_q) : COUNT_W'(len_q + 1'b1);
          state_d   = ST_IDLE;
        end else begin
          rd_idx_d = pos_q + 1'b1;
          wr_idx_d = pos_q;
          state_d  = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // Entries after the victim move down one place; each is written in the cycle after its read.
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        s1_valid_d = issue;
        if (s1_valid_q) begin
          frame_we = 1'b1;
          wr_idx_d = wr_idx_q + 1'b1;
        end else if (!issue) begin
          frame_we  = 1'b1;
          frame_wa  = len_m1[IDX_W-1:0];
          frame_wd  = pg_q;
          ref_we    = 1'b1;
          mod_we    = kind_q;
          done_d    = 1'b1;
          out_hit_d = 1'b0;
          out_ev_d  = 1'b1;
          out_vp_d  = victim_q;
          out_cnt_d = COUNT_W'(len_q);
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      frames_q   <= FRAMES_RESET;
      clr_q      <= '0;
      pg_q       <= '0;
      kind_q     <= 1'b0;
      len_q      <= '0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      s1_valid_q <= 1'b0;
      s1_idx_q   <= '0;
      s2_valid_q <= 1'b0;
      s2_idx_q   <= '0;
      s2_page_q  <= '0;
      hit_q      <= 1'b0;
      least_q    <= CLASS_CEILING;
      pos_q      <= '0;
      victim_q   <= '0;
      done_q     <= 1'b0;
      out_hit_q  <= 1'b0;
      out_ev_q   <= 1'b0;
      out_vp_q   <= '0;
      out_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      if (cfg_valid_i) begin
        frames_q <= cfg_data_i;
      end
      clr_q      <= clr_d;
      pg_q       <= pg_d;
      kind_q     <= kind_d;
      len_q      <= len_d;
      rd_idx_q   <= rd_idx_d;
      wr_idx_q   <= wr_idx_d;
      s1_valid_q <= s1_valid_d;
      s1_idx_q   <= s1_idx_d;
      s2_valid_q <= s2_valid_d;
      s2_idx_q   <= s2_idx_d;
      s2_page_q  <= s2_page_d;
      hit_q      <= hit_d;
      least_q    <= least_d;
      pos_q      <= pos_d;
      victim_q   <= victim_d;
      done_q     <= done_d;
      out_hit_q  <= out_hit_d;
      out_ev_q   <= out_ev_d;
      out_vp_q   <= out_vp_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[frame_wa] <= frame_wd;
    end
    frame_rd_q <= frame_mem[frame_ra];
  end

  // The bit tables are looked up at the page just read from the list.
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[bit_wa] <= ref_wd;
    end
    if (mod_we) begin
      mod_mem[bit_wa] <= mod_wd;
    end
    ref_rd_q <= ref_mem[frame_rd_q];
    mod_rd_q <= mod_mem[frame_rd_q];
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for nru_page_replacement: random and directed page accesses,
// compared field by field against a predictor of the NRU frame list kept in a scoreboard.
// Depends on nru_pkg and the nru_page_replacement RTL only.
module tb;

  localparam int unsigned MAX_FRAMES = nru_pkg::DEF_MAX_FRAMES;
  localparam int unsigned PAGE_BITS  = nru_pkg::DEF_PAGE_BITS;
  localparam int unsigned PAGE_SPACE = 1 << PAGE_BITS;
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic                        hit;
    logic                        evicted;
    logic [PAGE_BITS-1:0]        victim;
    logic [nru_pkg::COUNT_W-1:0] count;
  } access_result_t;

  // Keeps a private copy of the frame list and the page bit tables, and predicts one
  // result per accepted request.
  class nru_scoreboard;
    logic [PAGE_BITS-1:0]     frames[MAX_FRAMES];
    int unsigned              length;
    bit                       refd[PAGE_SPACE];
    bit                       modf[PAGE_SPACE];
    logic [nru_pkg::CFG_W-1:0] limit;
    access_result_t           awaited[$];
    int unsigned              errors;
    int unsigned              accesses;
    int unsigned              hits;
    int unsigned              evictions;

    function new();
      length    = 0;
      limit     = nru_pkg::FRAMES_RESET;
      errors    = 0;
      accesses  = 0;
      hits      = 0;
      evictions = 0;
      foreach (refd[i]) begin
        refd[i] = 1'b0;
        modf[i] = 1'b0;
      end
    endfunction

    function void set_limit(logic [nru_pkg::CFG_W-1:0] value);
      limit = value;
    endfunction

    function int unsigned frame_cap();
      if (limit == 0) return 1;
      if (limit > MAX_FRAMES) return MAX_FRAMES;
      return limit;
    endfunction

    function void note_access(logic [PAGE_BITS-1:0] page, logic kind);
      access_result_t r;
      int unsigned    least;
      int unsigned    pos;
      int unsigned    cls;
      r     = '0;
      least = nru_pkg::CLASS_CEILING;
      pos   = 0;
      for (int unsigned k = 0; k < length; k++) begin
        if (frames[k] == page) begin
          r.hit = 1'b1;
          break;
        end
      end
      if (!r.hit) begin
        if (length < frame_cap()) begin
          frames[length] = page;
          length++;
        end else if (length > 0) begin
          // Earliest entry wins a tie, hence the strict comparison.
          for (int unsigned k = 0; k < length; k++) begin
            cls = 2 * refd[frames[k]] + modf[frames[k]];
            if (cls < least) begin
              least = cls;
              pos   = k;
            end
          end
          r.evicted = 1'b1;
          r.victim  = frames[pos];
          for (int unsigned k = pos; k + 1 < length; k++) frames[k] = frames[k+1];
          frames[length-1] = page;
        end
      end
      refd[page] = 1'b1;
      if (kind == KIND_WRITE) modf[page] = 1'b1;
      r.count = nru_pkg::COUNT_W'(length);
      accesses++;
      if (r.hit) hits++;
      if (r.evicted) evictions++;
      awaited = {awaited, r};
    endfunction

    function void check_result(access_result_t got);
      access_result_t exp;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding: hit %0d evicted %0d victim %0d count %0d",
               got.hit, got.evicted, got.victim, got.count);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, got.hit);
        errors++;
      end
      if (got.evicted !== exp.evicted) begin
        $error("evicted: expected %0d, got %0d", exp.evicted, got.evicted);
        errors++;
      end
      if (got.victim !== exp.victim) begin
        $error("victim_page: expected %0d, got %0d", exp.victim, got.victim);
        errors++;
      end
      if (got.count !== exp.count) begin
        $error("resident_count: expected %0d, got %0d", exp.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [PAGE_BITS-1:0]        page_i = '0;
  logic                        kind_i = KIND_READ;
  logic                        done_o;
  logic                        hit_o;
  logic                        evicted_o;
  logic [PAGE_BITS-1:0]        victim_page_o;
  logic [nru_pkg::COUNT_W-1:0] resident_count_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [nru_pkg::CFG_W-1:0]   cfg_data_i = '0;

  nru_scoreboard sb = new();
  int unsigned   limit_writes = 0;
  int unsigned   burst_left = 0;

  nru_page_replacement #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .page_i           (page_i),
    .kind_i           (kind_i),
    .done_o           (done_o),
    .hit_o            (hit_o),
    .evicted_o        (evicted_o),
    .victim_page_o    (victim_page_o),
    .resident_count_o (resident_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Results are checked before the request of the same edge is noted; the queue keeps order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result({hit_o, evicted_o, victim_page_o, resident_count_o});
      if (start_i && !busy_o) sb.note_access(page_i, kind_i);
    end
  end

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_access(input logic [PAGE_BITS-1:0] page, input logic kind);
    start_i <= 1'b1;
    page_i  <= page;
    kind_i  <= kind;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(input int unsigned cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Returns only once the block is idle with every result seen.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (busy_o || (sb.awaited.size() != 0));
  endtask

  task automatic write_limit(input logic [nru_pkg::CFG_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(value);
    limit_writes++;
  endtask

  // Bursts of back-to-back requests separated by random gaps, some of them long.
  task automatic paced_access(input logic [PAGE_BITS-1:0] page, input logic kind);
    send_access(page, kind);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45));
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    logic [nru_pkg::CFG_W-1:0] lim;
    logic [PAGE_BITS-1:0]      base;
    int unsigned               span;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: fill, evict by class, ties, limit below length, limits out of range.
    write_limit(nru_pkg::CFG_W'(3));
    send_access(8'd0,   KIND_READ);
    send_access(8'd255, KIND_WRITE);
    send_access(8'd0,   KIND_WRITE);
    send_access(8'd128, KIND_READ);
    send_access(8'd7,   KIND_READ);
    send_access(8'd1,   KIND_WRITE);
    send_access(8'd2,   KIND_WRITE);
    send_access(8'd128, KIND_WRITE);
    write_limit(nru_pkg::CFG_W'(1));
    send_access(8'd64,  KIND_READ);
    send_access(8'd255, KIND_READ);
    write_limit(nru_pkg::CFG_W'(0));
    send_access(8'd170, KIND_WRITE);
    send_access(8'd85,  KIND_READ);
    write_limit(nru_pkg::CFG_W'(31));
    for (int i = 0; i < 15; i++) send_access(8'(200 + i), (i % 3 == 0) ? KIND_WRITE : KIND_READ);

    // Random part: a drifting working set near the frame limit gives a mix of hits,
    // appends and evictions; one request in four goes anywhere in the page space.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       lim = nru_pkg::CFG_W'(16);
        1:       lim = nru_pkg::CFG_W'(1);
        2:       lim = nru_pkg::CFG_W'(0);
        3:       lim = nru_pkg::CFG_W'(31);
        4:       lim = nru_pkg::CFG_W'(2);
        default: lim = nru_pkg::CFG_W'($urandom_range(0, 31));
      endcase
      write_limit(lim);
      span = sb.frame_cap() + $urandom_range(0, 4);
      base = PAGE_BITS'($urandom_range(0, PAGE_SPACE - 1));
      for (int i = 0; i < 95; i++) begin
        if (i % 30 == 29) base = PAGE_BITS'($urandom_range(0, PAGE_SPACE - 1));
        if ($urandom_range(0, 3) == 0)
          paced_access(PAGE_BITS'($urandom_range(0, PAGE_SPACE - 1)),
                       1'($urandom_range(0, 1)));
        else
          paced_access(PAGE_BITS'(base + $urandom_range(0, span)),
                       1'($urandom_range(0, 1)));
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d accesses over %0d frame limit settings: %0d hits, %0d evictions.",
             sb.accesses, limit_writes, sb.hits, sb.evictions);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("nru_page_replacement: match");
    end else begin
      if (sb.awaited.size() != 0) $error("%0d results never arrived", sb.awaited.size());
      $display("nru_page_replacement: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", sb.awaited.size());
    $display("nru_page_replacement: mismatch");
    $finish;
  end

endmodule

FILE: nru_page_replacement.f
rtl/core/nru_pkg.sv
rtl/core/nru_page_replacement.sv
tb/sv/tb.sv
